// ----- hw/rtl/tkc_pkg.sv -----
// ============================================================================
// tkc_pkg - shared definitions for the top-k count tracker
// Default sizes and the result flag bundle passed from the list core.
// ============================================================================
package tkc_pkg;

    localparam int TOP_SIZE_DEF   = 10;
    localparam int ID_BITS_DEF    = 16;
    localparam int COUNT_BITS_DEF = 32;

    // result flags of one update
    typedef struct packed {
        logic entered;
        logic evicted_valid;
    } flags_t;

endpackage

// ----- hw/rtl/tkc_in_stage.sv -----
// ============================================================================
// tkc_in_stage - input register
// Captures one play event per transfer and holds it until the list core
// takes it.
// ============================================================================
module tkc_in_stage #(
    parameter int ID_BITS    = tkc_pkg::ID_BITS_DEF,
    parameter int COUNT_BITS = tkc_pkg::COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ID_BITS-1:0]    s_item_id,
    input  logic [COUNT_BITS-1:0] s_prior_count,
    input  logic                  take,
    output logic                  item_valid,
    output logic [ID_BITS-1:0]    item_id,
    output logic [COUNT_BITS-1:0] item_count
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [ID_BITS-1:0]    id_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic                  load;

    assign s_ready = !valid_reg || take;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            id_reg  <= s_item_id;
            cnt_reg <= s_prior_count;
        end
    end

    assign item_valid = valid_reg;
    assign item_id    = id_reg;
    assign item_count = cnt_reg;

endmodule

// ----- hw/rtl/tkc_list.sv -----
// ============================================================================
// tkc_list - ranked list storage, update logic and result register
// Compares the held item against every entry in parallel, applies one
// move-up or insert per cycle while the result side keeps up, and registers the result.
// ============================================================================
module tkc_list #(
    parameter int TOP_SIZE   = tkc_pkg::TOP_SIZE_DEF,
    parameter int ID_BITS    = tkc_pkg::ID_BITS_DEF,
    parameter int COUNT_BITS = tkc_pkg::COUNT_BITS_DEF,
    parameter int RANK_W     = $clog2(TOP_SIZE + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_valid,
    input  logic [ID_BITS-1:0]    item_id,
    input  logic [COUNT_BITS-1:0] item_count,
    output logic                  take,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [RANK_W-1:0]     rank,
    output tkc_pkg::flags_t       flags,
    output logic [ID_BITS-1:0]    evicted_id,
    output logic [RANK_W-1:0]     list_size
);

    localparam logic [RANK_W-1:0] FULL = RANK_W'(TOP_SIZE);

    logic [ID_BITS-1:0]    ids_reg  [TOP_SIZE];
    logic [ID_BITS-1:0]    ids_next [TOP_SIZE];
    logic [COUNT_BITS-1:0] cnts_reg [TOP_SIZE];
    logic [COUNT_BITS-1:0] cnts_next[TOP_SIZE];
    logic [RANK_W-1:0]     size_reg;
    logic [RANK_W-1:0]     size_next;

    logic                  out_valid_reg;
    logic [RANK_W-1:0]     rank_reg;
    logic [RANK_W-1:0]     rank_next;
    tkc_pkg::flags_t       flags_reg;
    tkc_pkg::flags_t       flags_next;
    logic [ID_BITS-1:0]    ev_id_reg;
    logic [ID_BITS-1:0]    ev_id_next;

    logic [COUNT_BITS-1:0] cnt_inc;
    logic [TOP_SIZE-1:0]   match;
    logic [TOP_SIZE-1:0]   ge;
    logic [TOP_SIZE-1:0]   le;
    logic [TOP_SIZE-1:0]   eq;
    logic                  found;
    logic [RANK_W-1:0]     hit_idx;
    logic [RANK_W-1:0]     up_pos;
    logic                  any_le;
    logic                  eq_first;
    logic [RANK_W-1:0]     first_le;
    logic [RANK_W-1:0]     ins_pos;
    logic                  reject;

    assign take = item_valid && (!out_valid_reg || m_ready);

    assign cnt_inc = (item_count == {COUNT_BITS{1'b1}}) ? item_count
                                                        : item_count + COUNT_BITS'(1);

    // per-entry compares, only entries below the fill count take part in match and le
    always_comb begin
        for (int j = 0; j < TOP_SIZE; j++) begin
            match[j] = (RANK_W'(j) < size_reg) && (ids_reg[j] == item_id);
            ge[j]    = cnts_reg[j] >= cnt_inc;
            le[j]    = (RANK_W'(j) < size_reg) && (cnts_reg[j] <= cnt_inc);
            eq[j]    = cnts_reg[j] == cnt_inc;
        end
    end

    // priority encoders: first match, first entry not above the new count
    always_comb begin
        found    = 1'b0;
        hit_idx  = '0;
        any_le   = 1'b0;
        first_le = '0;
        eq_first = 1'b0;
        for (int j = TOP_SIZE - 1; j >= 0; j--) begin
            if (match[j]) begin
                found   = 1'b1;
                hit_idx = RANK_W'(j);
            end
            if (le[j]) begin
                any_le   = 1'b1;
                first_le = RANK_W'(j);
                eq_first = eq[j];
            end
        end
    end

    // listed item moves up to just behind the last entry ahead of it that is not smaller
    always_comb begin
        up_pos = '0;
        for (int j = 0; j < TOP_SIZE; j++) begin
            if (RANK_W'(j) < hit_idx && ge[j]) begin
                up_pos = RANK_W'(j + 1);
            end
        end
    end

    assign ins_pos = any_le ? first_le + {{(RANK_W-1){1'b0}}, eq_first} : size_reg;
    assign reject  = (size_reg == FULL) && !le[TOP_SIZE-1];

    always_comb begin
        for (int j = 0; j < TOP_SIZE; j++) begin
            ids_next[j]  = ids_reg[j];
            cnts_next[j] = cnts_reg[j];
        end
        size_next  = size_reg;
        rank_next  = FULL;
        flags_next = '0;
        ev_id_next = '0;
        if (found) begin
            for (int j = 0; j < TOP_SIZE; j++) begin
                if (RANK_W'(j) == up_pos) begin
                    ids_next[j]  = item_id;
                    cnts_next[j] = cnt_inc;
                end else if (j > 0 && RANK_W'(j) > up_pos && RANK_W'(j) <= hit_idx) begin
                    ids_next[j]  = ids_reg[j-1];
                    cnts_next[j] = cnts_reg[j-1];
                end
            end
            rank_next = up_pos;
        end else if (reject) begin
            rank_next = FULL;
        end else if (ins_pos >= FULL) begin
            // lands past the tail of a full list: the item itself drops out
            flags_next.evicted_valid = 1'b1;
            ev_id_next               = item_id;
        end else begin
            for (int j = 0; j < TOP_SIZE; j++) begin
                if (RANK_W'(j) == ins_pos) begin
                    ids_next[j]  = item_id;
                    cnts_next[j] = cnt_inc;
                end else if (j > 0 && RANK_W'(j) > ins_pos) begin
                    ids_next[j]  = ids_reg[j-1];
                    cnts_next[j] = cnts_reg[j-1];
                end
            end
            if (size_reg == FULL) begin
                flags_next.evicted_valid = 1'b1;
                ev_id_next               = ids_reg[TOP_SIZE-1];
            end else begin
                size_next = size_reg + RANK_W'(1);
            end
            flags_next.entered = 1'b1;
            rank_next          = ins_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                size_reg      <= size_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            for (int j = 0; j < TOP_SIZE; j++) begin
                ids_reg[j]  <= ids_next[j];
                cnts_reg[j] <= cnts_next[j];
            end
            rank_reg  <= rank_next;
            flags_reg <= flags_next;
            ev_id_reg <= ev_id_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign rank       = rank_reg;
    assign flags      = flags_reg;
    assign evicted_id = ev_id_reg;
    assign list_size  = size_reg;

    a_size_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        size_reg <= FULL)
        else $error("fill count beyond list depth");

    a_size_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !take |=> $stable(size_reg))
        else $error("fill count changed without an update");

    a_take_result: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> out_valid_reg)
        else $error("update without a result");

    a_entered_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && flags_reg.entered) |-> (rank_reg < FULL && size_reg != '0))
        else $error("inserted item not listed");

endmodule

// ----- hw/rtl/top_k_count_tracker_unit.sv -----
// ============================================================================
// top_k_count_tracker_unit - ranked play-count list
// Keeps the TOP_SIZE most played items in count order and reports each update.
// ============================================================================
// One play event is taken per cycle when the result side keeps up. Each event
// sits in an input register, is compared against all list entries at once,
// and its move-up or insert is written to the list, with the result into the
// result register, once that register is free or being read. The list starts
// empty after reset; no clearing pass is needed.
module top_k_count_tracker_unit #(
    parameter int TOP_SIZE   = tkc_pkg::TOP_SIZE_DEF,
    parameter int ID_BITS    = tkc_pkg::ID_BITS_DEF,
    parameter int COUNT_BITS = tkc_pkg::COUNT_BITS_DEF,
    parameter int RANK_W     = $clog2(TOP_SIZE + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ID_BITS-1:0]    s_item_id,
    input  logic [COUNT_BITS-1:0] s_prior_count,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [RANK_W-1:0]     m_rank,
    output logic                  m_entered,
    output logic                  m_evicted_valid,
    output logic [ID_BITS-1:0]    m_evicted_id,
    output logic [RANK_W-1:0]     m_list_size
);

    logic                  item_valid;
    logic [ID_BITS-1:0]    item_id;
    logic [COUNT_BITS-1:0] item_count;
    logic                  take;
    tkc_pkg::flags_t       flags;

    tkc_in_stage #(
        .ID_BITS    (ID_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_in_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item_id     (s_item_id),
        .s_prior_count (s_prior_count),
        .take          (take),
        .item_valid    (item_valid),
        .item_id       (item_id),
        .item_count    (item_count)
    );

    tkc_list #(
        .TOP_SIZE   (TOP_SIZE),
        .ID_BITS    (ID_BITS),
        .COUNT_BITS (COUNT_BITS),
        .RANK_W     (RANK_W)
    ) u_list (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_id    (item_id),
        .item_count (item_count),
        .take       (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .rank       (m_rank),
        .flags      (flags),
        .evicted_id (m_evicted_id),
        .list_size  (m_list_size)
    );

    assign m_entered       = flags.entered;
    assign m_evicted_valid = flags.evicted_valid;

endmodule
